/* hw/rtl/vang3_pkg.sv */
// Shared types, constants and step functions for the 3D vector angle core.
// No dependencies; imported by vector_angle_3d_core.
`default_nettype none

package vang3_pkg;

    localparam int LIMIT_W  = 48;
    localparam int CORDIC_N = 30;
    localparam int CW       = 34;   // CORDIC x/y width, covers the gain growth

    localparam logic [30:0] COS_ONE     = 31'h4000_0000;
    localparam logic [63:0] COS_ONE_SQ  = 64'h1000_0000_0000_0000;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [63:0] r;
        logic [31:0] q;
        logic        sat;
    } t_div;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [32:0]   z;
    } t_cordic;

    typedef struct packed {
        logic dneg;
        logic undef;
    } t_side;

    // One digit of the restoring integer square root.
    function automatic t_sqrt sqrt_step(t_sqrt cur, logic [63:0] bitv);
        t_sqrt       n;
        logic [63:0] t;
        n = cur;
        t = cur.res + bitv;
        if (cur.v >= t) begin
            n.v   = cur.v - t;
            n.res = (cur.res >> 1) + bitv;
        end else begin
            n.res = cur.res >> 1;
        end
        return n;
    endfunction

    // One quotient bit of the long division, with saturation above one.
    function automatic t_div div_step(t_div cur, logic [63:0] den);
        t_div        n;
        logic [63:0] r2;
        logic        take;
        r2    = {cur.r[62:0], 1'b0};
        take  = cur.r[63] || (r2 >= den);
        n.r   = take ? r2 - den : r2;
        n.q   = {cur.q[30:0], take};
        n.sat = cur.sat || (n.q > 32'(COS_ONE));
        return n;
    endfunction

    function automatic logic signed [32:0] atan_q30(int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'h3243F6A8;
            1:       a = 32'h1DAC6705;
            2:       a = 32'h0FADBAFC;
            3:       a = 32'h07F56EA6;
            4:       a = 32'h03FEAB76;
            5:       a = 32'h01FFD55B;
            6:       a = 32'h00FFFAAA;
            7:       a = 32'h007FFF55;
            8:       a = 32'h003FFFEA;
            9:       a = 32'h001FFFFD;
            10:      a = 32'h000FFFFF;
            11:      a = 32'h0007FFFF;
            12:      a = 32'h0003FFFF;
            13:      a = 32'h0001FFFF;
            14:      a = 32'h0000FFFF;
            15:      a = 32'h00007FFF;
            16:      a = 32'h00003FFF;
            17:      a = 32'h00001FFF;
            18:      a = 32'h00000FFF;
            19:      a = 32'h000007FF;
            20:      a = 32'h000003FF;
            21:      a = 32'h000001FF;
            22:      a = 32'h000000FF;
            23:      a = 32'h0000007F;
            24:      a = 32'h0000003F;
            25:      a = 32'h0000001F;
            26:      a = 32'h0000000F;
            27:      a = 32'h00000008;
            28:      a = 32'h00000004;
            29:      a = 32'h00000002;
            default: a = 32'h0;
        endcase
        return signed'({1'b0, a});
    endfunction

    // One vectoring rotation; holds once y has reached zero.
    function automatic t_cordic cordic_step(t_cordic c, int i);
        t_cordic              n;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        n  = c;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.y > 0) begin
            n.x = c.x + dx;
            n.y = c.y - dy;
            n.z = c.z + atan_q30(i);
        end else if (c.y < 0) begin
            n.x = c.x - dx;
            n.y = c.y + dy;
            n.z = c.z - atan_q30(i);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vector_angle_3d_core.sv */
// Angle between two 3D vectors: one transaction per cycle while the output is not stalled,
// no gaps between transactions. Stages: products, sums, scale and signed dot, two 32-step
// square roots, magnitude multiply, limit check, one-bit-a-stage divider, cosine square,
// 31-step square root, 30-step CORDIC, clamp and quadrant fold, final rounding.
// The whole pipe halts only while the output register holds a stalled result.
// Synchronous active-low reset clears valid bits and the limit register (to 0).
`default_nettype none

module vector_angle_3d_core #(
    parameter int COMPONENT_BITS      = 24,
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [COMPONENT_BITS-1:0]   i_a_x,
    input  wire logic signed [COMPONENT_BITS-1:0]   i_a_y,
    input  wire logic signed [COMPONENT_BITS-1:0]   i_a_z,
    input  wire logic signed [COMPONENT_BITS-1:0]   i_b_x,
    input  wire logic signed [COMPONENT_BITS-1:0]   i_b_y,
    input  wire logic signed [COMPONENT_BITS-1:0]   i_b_z,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [ANGLE_FRACTION_BITS+1:0]          o_angle,
    output logic                                    o_undefined,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [vang3_pkg::LIMIT_W-1:0]      i_cfg_wr_data
);
    import vang3_pkg::*;

    localparam int CB   = COMPONENT_BITS;
    localparam int S    = 32 - COMPONENT_BITS;
    localparam int PW   = 2 * COMPONENT_BITS;
    localparam int DIVN = 2 * S + 30;
    localparam int SH   = 30 - ANGLE_FRACTION_BITS;
    localparam int AW   = ANGLE_FRACTION_BITS + 2;
    localparam int SQ1N = 32;
    localparam int SQ2N = 31;
    localparam logic [AW-1:0] ANG_MAX = AW'((33'(PI_Q30) + (33'd1 << (SH - 1))) >> SH);

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // ---------------- config ----------------
    logic [LIMIT_W-1:0] r_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // ---------------- stage 1: abs and products ----------------
    logic signed [CB-1:0] ain [3];
    logic signed [CB-1:0] bin [3];
    logic [CB-1:0]        ma  [3];
    logic [CB-1:0]        mb  [3];
    logic                 na  [3];
    logic                 nb  [3];

    assign ain[0] = i_a_x;
    assign ain[1] = i_a_y;
    assign ain[2] = i_a_z;
    assign bin[0] = i_b_x;
    assign bin[1] = i_b_y;
    assign bin[2] = i_b_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            na[i] = ain[i][CB-1];
            nb[i] = bin[i][CB-1];
            ma[i] = na[i] ? CB'(~ain[i]) + CB'(1) : CB'(ain[i]);
            mb[i] = nb[i] ? CB'(~bin[i]) + CB'(1) : CB'(bin[i]);
        end
    end

    logic          r_v1;
    logic [PW-1:0] r_pa [3];
    logic [PW-1:0] r_pb [3];
    logic [PW-1:0] r_px [3];
    logic          r_xn [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= PW'(ma[i]) * PW'(ma[i]);
                r_pb[i] <= PW'(mb[i]) * PW'(mb[i]);
                r_px[i] <= PW'(ma[i]) * PW'(mb[i]);
                r_xn[i] <= na[i] ^ nb[i];
            end
        end
    end

    // ---------------- stage 2: sums ----------------
    logic [PW-1:0] n_pos;
    logic [PW-1:0] n_neg;
    always_comb begin
        n_pos = '0;
        n_neg = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_xn[i]) begin
                n_neg = n_neg + r_px[i];
            end else begin
                n_pos = n_pos + r_px[i];
            end
        end
    end

    logic          r_v2;
    logic [PW-1:0] r_sqa;
    logic [PW-1:0] r_sqb;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqa <= r_pa[0] + r_pa[1] + r_pa[2];
            r_sqb <= r_pb[0] + r_pb[1] + r_pb[2];
            r_pos <= n_pos;
            r_neg <= n_neg;
        end
    end

    // ---------------- stage 3: scale, signed dot ----------------
    logic          r_v3;
    logic [63:0]   r_sqa64;
    logic [63:0]   r_sqb64;
    logic [PW-1:0] r_adot3;
    logic          r_dneg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqa64 <= 64'(r_sqa) << (2 * S);
            r_sqb64 <= 64'(r_sqb) << (2 * S);
            r_dneg3 <= r_neg > r_pos;
            r_adot3 <= (r_neg > r_pos) ? r_neg - r_pos : r_pos - r_neg;
        end
    end

    // ---------------- magnitude square roots ----------------
    logic [SQ1N-1:0] r_vsa;
    t_sqrt           r_sa   [SQ1N];
    t_sqrt           r_sb   [SQ1N];
    t_sqrt           n_sa   [SQ1N];
    t_sqrt           n_sb   [SQ1N];
    logic [PW-1:0]   r_sadot [SQ1N];
    logic            r_sdneg [SQ1N];

    always_comb begin
        n_sa[0] = sqrt_step('{v: r_sqa64, res: 64'd0}, 64'd1 << 62);
        n_sb[0] = sqrt_step('{v: r_sqb64, res: 64'd0}, 64'd1 << 62);
        for (int k = 1; k < SQ1N; k++) begin
            n_sa[k] = sqrt_step(r_sa[k-1], 64'd1 << (62 - 2 * k));
            n_sb[k] = sqrt_step(r_sb[k-1], 64'd1 << (62 - 2 * k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsa <= '0;
        end else if (adv) begin
            r_vsa <= {r_vsa[SQ1N-2:0], r_v3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sadot[0] <= r_adot3;
            r_sdneg[0] <= r_dneg3;
            for (int k = 0; k < SQ1N; k++) begin
                r_sa[k] <= n_sa[k];
                r_sb[k] <= n_sb[k];
            end
            for (int k = 1; k < SQ1N; k++) begin
                r_sadot[k] <= r_sadot[k-1];
                r_sdneg[k] <= r_sdneg[k-1];
            end
        end
    end

    // ---------------- magnitude product ----------------
    logic          r_vm;
    logic [63:0]   r_prod_m;
    logic [PW-1:0] r_adot_m;
    logic          r_dneg_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (adv) begin
            r_vm <= r_vsa[SQ1N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod_m <= 64'(r_sa[SQ1N-1].res[31:0]) * 64'(r_sb[SQ1N-1].res[31:0]);
            r_adot_m <= r_sadot[SQ1N-1];
            r_dneg_m <= r_sdneg[SQ1N-1];
        end
    end

    // ---------------- limit check, divider setup ----------------
    logic        r_vl;
    t_div        r_div_l;
    logic [63:0] r_prod_l;
    t_side       r_side_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= 1'b0;
        end else if (adv) begin
            r_vl <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_div_l.r      <= 64'(r_adot_m);
            r_div_l.q      <= '0;
            r_div_l.sat    <= 64'(r_adot_m) >= r_prod_m;
            r_prod_l       <= r_prod_m;
            r_side_l.dneg  <= r_dneg_m;
            r_side_l.undef <= (r_prod_m >> (2 * S)) <= 64'(r_limit);
        end
    end

    // ---------------- cosine divider ----------------
    logic [DIVN-1:0] r_vd;
    t_div            r_dv   [DIVN];
    t_div            n_dv   [DIVN];
    logic [63:0]     r_dp   [DIVN];
    t_side           r_dside [DIVN];

    always_comb begin
        n_dv[0] = div_step(r_div_l, r_prod_l);
        for (int k = 1; k < DIVN; k++) begin
            n_dv[k] = div_step(r_dv[k-1], r_dp[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (adv) begin
            r_vd <= {r_vd[DIVN-2:0], r_vl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dp[0]    <= r_prod_l;
            r_dside[0] <= r_side_l;
            for (int k = 0; k < DIVN; k++) begin
                r_dv[k] <= n_dv[k];
            end
            for (int k = 1; k < DIVN; k++) begin
                r_dp[k]    <= r_dp[k-1];
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // ---------------- cosine square ----------------
    logic [30:0] qf;
    assign qf = (r_dv[DIVN-1].sat || r_dv[DIVN-1].q > 32'(COS_ONE))
                ? COS_ONE : r_dv[DIVN-1].q[30:0];

    logic        r_vq;
    logic [30:0] r_cos_q;
    logic [61:0] r_csq_q;
    t_side       r_side_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else if (adv) begin
            r_vq <= r_vd[DIVN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cos_q  <= qf;
            r_csq_q  <= 62'(qf) * 62'(qf);
            r_side_q <= r_dside[DIVN-1];
        end
    end

    logic        r_vr;
    logic [60:0] r_rad_r;
    logic [30:0] r_cos_r;
    t_side       r_side_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (adv) begin
            r_vr <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad_r  <= 61'(COS_ONE_SQ - 64'(r_csq_q));
            r_cos_r  <= r_cos_q;
            r_side_r <= r_side_q;
        end
    end

    // ---------------- sine square root ----------------
    logic [SQ2N-1:0] r_vsc;
    t_sqrt           r_sc    [SQ2N];
    t_sqrt           n_sc    [SQ2N];
    logic [30:0]     r_sccos [SQ2N];
    t_side           r_scside [SQ2N];

    always_comb begin
        n_sc[0] = sqrt_step('{v: 64'(r_rad_r), res: 64'd0}, 64'd1 << 60);
        for (int k = 1; k < SQ2N; k++) begin
            n_sc[k] = sqrt_step(r_sc[k-1], 64'd1 << (60 - 2 * k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsc <= '0;
        end else if (adv) begin
            r_vsc <= {r_vsc[SQ2N-2:0], r_vr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sccos[0]  <= r_cos_r;
            r_scside[0] <= r_side_r;
            for (int k = 0; k < SQ2N; k++) begin
                r_sc[k] <= n_sc[k];
            end
            for (int k = 1; k < SQ2N; k++) begin
                r_sccos[k]  <= r_sccos[k-1];
                r_scside[k] <= r_scside[k-1];
            end
        end
    end

    // ---------------- CORDIC atan2(sin, cos) ----------------
    t_cordic               cd_in;
    logic [CORDIC_N-1:0]   r_vc;
    t_cordic               r_cd    [CORDIC_N];
    t_cordic               n_cd    [CORDIC_N];
    t_side                 r_cdside [CORDIC_N];

    always_comb begin
        cd_in.x = signed'(CW'(r_sccos[SQ2N-1]));
        cd_in.y = signed'(CW'(r_sc[SQ2N-1].res[30:0]));
        cd_in.z = '0;
        n_cd[0] = cordic_step(cd_in, 0);
        for (int k = 1; k < CORDIC_N; k++) begin
            n_cd[k] = cordic_step(r_cd[k-1], k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= '0;
        end else if (adv) begin
            r_vc <= {r_vc[CORDIC_N-2:0], r_vsc[SQ2N-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cdside[0] <= r_scside[SQ2N-1];
            for (int k = 0; k < CORDIC_N; k++) begin
                r_cd[k] <= n_cd[k];
            end
            for (int k = 1; k < CORDIC_N; k++) begin
                r_cdside[k] <= r_cdside[k-1];
            end
        end
    end

    // ---------------- clamp, quadrant fold ----------------
    logic signed [32:0] zf;
    logic [31:0]        zc;
    assign zf = r_cd[CORDIC_N-1].z;

    always_comb begin
        if (zf < 0) begin
            zc = '0;
        end else if (zf > signed'({1'b0, HALF_PI_Q30})) begin
            zc = HALF_PI_Q30;
        end else begin
            zc = zf[31:0];
        end
    end

    logic        r_vz;
    logic [31:0] r_ang_z;
    t_side       r_side_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vz <= 1'b0;
        end else if (adv) begin
            r_vz <= r_vc[CORDIC_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang_z  <= r_cdside[CORDIC_N-1].dneg ? PI_Q30 - zc : zc;
            r_side_z <= r_cdside[CORDIC_N-1];
        end
    end

    // ---------------- rounding, output register ----------------
    logic [32:0] ang_rnd;
    assign ang_rnd = 33'(r_ang_z) + (33'd1 << (SH - 1));

    logic          r_vo;
    logic [AW-1:0] r_angle;
    logic          r_undef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vo <= r_vz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_angle <= r_side_z.undef ? '0 : ang_rnd[SH +: AW];
            r_undef <= r_side_z.undef;
        end
    end

    assign o_valid     = r_vo;
    assign o_angle     = r_angle;
    assign o_undefined = r_undef;

    // ---------------- assertions ----------------
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_undefined |-> o_angle == '0)
        else $error("undefined result with nonzero angle");

    a_angle_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle <= ANG_MAX)
        else $error("angle above pi");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_stall) |-> r_vd == $past(r_vd))
        else $error("divider valids moved during stall");

    a_cordic_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_stall) |-> r_vc == $past(r_vc))
        else $error("CORDIC valids moved during stall");

endmodule

`default_nettype wire
